// File: rtl/core/fddm_pkg.sv
// ----------------------------------------------------------------------------
// fddm_pkg
// Shared types, constants and helper functions for the four-digit display
// multiplexer: transfer payloads, pipeline item, segment table and digit split.
// ----------------------------------------------------------------------------
package fddm_pkg;

  // Operation codes carried by an input transfer.
  typedef enum logic {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } op_t;

  // Fixed field widths.
  localparam int unsigned VALUE_W  = 14;
  localparam int unsigned SEG_W    = 7;
  localparam int unsigned GRID_W   = 4;
  localparam int unsigned ACTIVE_W = 2;
  localparam int unsigned BRIGHT_W = 7;
  localparam int unsigned SLOT_W   = 7;
  localparam int unsigned HALF_W   = 7;   // holds 0..99
  localparam int unsigned DIGIT_W  = 4;
  localparam int unsigned CONV_DIGITS = 4;

  // Scan timing and limits.
  localparam logic [SLOT_W-1:0]   SEG_LOAD_COUNT = 7'd5;
  localparam logic [SLOT_W-1:0]   SLOT_LAST      = 7'd125;
  localparam logic [SLOT_W:0]     SLOT_SPAN      = 8'd126;
  localparam logic [VALUE_W-1:0]  VALUE_MAX      = 14'd9999;
  localparam logic [BRIGHT_W-1:0] BRIGHT_RESET   = 7'd100;

  // Reciprocal constants: x / 100 for x <= 9999, and x / 10 for x <= 99.
  localparam logic [26:0] RECIP_100 = 27'd5243;
  localparam int unsigned SHIFT_100 = 19;
  localparam logic [13:0] RECIP_10  = 14'd103;
  localparam int unsigned SHIFT_10  = 10;

  // Input transfer payload.
  typedef struct packed {
    op_t                operation;
    logic [VALUE_W-1:0] value;
  } in_item_t;

  // Output transfer payload.
  typedef struct packed {
    logic [SEG_W-1:0]    segments;
    logic [GRID_W-1:0]   grid_enable;
    logic [ACTIVE_W-1:0] active_digit;
  } out_item_t;

  // Item leaving the digit split pipeline: the value in two halves of 0..99.
  typedef struct packed {
    logic              valid;
    op_t               op;
    logic [HALF_W-1:0] hi;
    logic [HALF_W-1:0] lo;
  } split_item_t;

  // Segment pattern of one decimal digit; anything above nine is blank.
  function automatic logic [SEG_W-1:0] pattern_of(input logic [DIGIT_W-1:0] d);
    logic [SEG_W-1:0] p;
    case (d)
      4'd0:    p = 7'b0111111;
      4'd1:    p = 7'b0000110;
      4'd2:    p = 7'b1011011;
      4'd3:    p = 7'b1001111;
      4'd4:    p = 7'b1100110;
      4'd5:    p = 7'b1101101;
      4'd6:    p = 7'b1111101;
      4'd7:    p = 7'b0000111;
      4'd8:    p = 7'b1111111;
      4'd9:    p = 7'b1101111;
      default: p = 7'b0000000;
    endcase
    return p;
  endfunction

  // Tens digit of a value from 0 to 99.
  function automatic logic [DIGIT_W-1:0] tens_of(input logic [HALF_W-1:0] x);
    logic [13:0] prod;
    prod = 14'(x) * RECIP_10;
    return DIGIT_W'(prod >> SHIFT_10);
  endfunction

  // Units digit of a value from 0 to 99.
  function automatic logic [DIGIT_W-1:0] ones_of(input logic [HALF_W-1:0] x);
    logic [HALF_W-1:0] t;
    t = HALF_W'(tens_of(x));
    return DIGIT_W'(x - HALF_W'(t * 7'd10));
  endfunction

endpackage

// File: rtl/core/fddm_digit_split.sv
// ----------------------------------------------------------------------------
// fddm_digit_split
// Three register stages: the input register, then two stages that saturate the
// loaded value and cut it into a high and a low half of 0..99 each, ready for
// the final digit split at commit.
// ----------------------------------------------------------------------------
module fddm_digit_split
  import fddm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  logic        in_valid,
  input  in_item_t    in_data,
  output split_item_t item
);

  // Stage one: the input register.
  logic               s1_valid;
  op_t                s1_op;
  logic [VALUE_W-1:0] s1_value;

  // Stage two: saturated value and its hundreds.
  logic               s2_valid;
  op_t                s2_op;
  logic [VALUE_W-1:0] s2_vsat;
  logic [HALF_W-1:0]  s2_q100;

  // Stage three: the two halves.
  logic               s3_valid;
  op_t                s3_op;
  logic [HALF_W-1:0]  s3_hi;
  logic [HALF_W-1:0]  s3_lo;

  logic [VALUE_W-1:0] vsat;
  logic [26:0]        prod100;
  logic [HALF_W-1:0]  q100;
  logic [HALF_W-1:0]  lo;

  // Saturate and divide by one hundred with a reciprocal multiply.
  always_comb begin
    vsat    = (s1_value > VALUE_MAX) ? VALUE_MAX : s1_value;
    prod100 = 27'(vsat) * RECIP_100;
    q100    = HALF_W'(prod100 >> SHIFT_100);
  end

  // Remainder after the hundreds; the product by one hundred is shift and add.
  assign lo = HALF_W'(s2_vsat - VALUE_W'(VALUE_W'(s2_q100) * 14'd100));

  // Valid bits of the three stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  // Payload of the three stages.
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_op    <= in_data.operation;
      s1_value <= in_data.value;
      s2_op    <= s1_op;
      s2_vsat  <= vsat;
      s2_q100  <= q100;
      s3_op    <= s2_op;
      s3_hi    <= s2_q100;
      s3_lo    <= lo;
    end
  end

  assign item.valid = s3_valid;
  assign item.op    = s3_op;
  assign item.hi    = s3_hi;
  assign item.lo    = s3_lo;

endmodule

// File: rtl/core/fddm_scan.sv
// ----------------------------------------------------------------------------
// fddm_scan
// Scan state and result register: digit store, slot counter, digit index,
// segment and grid latches, and the brightness register.
// ----------------------------------------------------------------------------
module fddm_scan
  import fddm_pkg::*;
#(
  parameter int unsigned NUM_DIGITS = 4
)
(
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  split_item_t         item,
  input  logic                cfg_wr_en,
  input  logic [BRIGHT_W-1:0] cfg_wr_data,
  output logic                out_valid,
  output out_item_t           out_data
);

  localparam int unsigned CUR_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

  logic [BRIGHT_W-1:0] brightness;
  logic [SLOT_W-1:0]   slot_counter;
  logic [SLOT_W-1:0]   slot_counter_next;
  logic [CUR_W-1:0]    current_digit;
  logic [CUR_W-1:0]    current_digit_next;
  logic [SEG_W-1:0]    segment_latch;
  logic [SEG_W-1:0]    segment_latch_next;
  logic [GRID_W-1:0]   grid_latch;
  logic [GRID_W-1:0]   grid_latch_next;
  logic [DIGIT_W-1:0]  digit_store      [NUM_DIGITS];
  logic [DIGIT_W-1:0]  digit_store_next [NUM_DIGITS];

  logic [DIGIT_W-1:0]    conv [8];
  logic [NUM_DIGITS-1:0] onehot;
  logic                  commit;
  logic                  grid_hit;

  // Decimal digits of the loaded value, units first; higher places are zero.
  always_comb begin
    conv[0] = ones_of(item.lo);
    conv[1] = tens_of(item.lo);
    conv[2] = ones_of(item.hi);
    conv[3] = tens_of(item.hi);
    for (int i = CONV_DIGITS; i < 8; i++) begin
      conv[i] = '0;
    end
  end

  assign commit   = advance && item.valid;
  assign onehot   = NUM_DIGITS'(1) << current_digit;
  assign grid_hit = ((SLOT_W + 1)'(slot_counter) + (SLOT_W + 1)'(brightness)) == SLOT_SPAN;

  // Next scan state: a load fills the store, a tick advances the slot.
  always_comb begin
    slot_counter_next  = slot_counter;
    current_digit_next = current_digit;
    segment_latch_next = segment_latch;
    grid_latch_next    = grid_latch;
    digit_store_next   = digit_store;
    if (commit) begin
      if (item.op == OP_LOAD) begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
          digit_store_next[i] = conv[i];
        end
      end else begin
        // Segment update wins over a grid switch-on at the same count.
        if (slot_counter == SEG_LOAD_COUNT) begin
          segment_latch_next = pattern_of(digit_store[current_digit]);
        end else if (grid_hit) begin
          grid_latch_next = GRID_W'(onehot);
        end
        // End of the slot: grid off and move to the next digit.
        if (slot_counter >= SLOT_LAST) begin
          grid_latch_next   = '0;
          slot_counter_next = '0;
          if (current_digit == CUR_W'(NUM_DIGITS - 1)) begin
            current_digit_next = '0;
          end else begin
            current_digit_next = current_digit + 1'b1;
          end
        end else begin
          slot_counter_next = slot_counter + 1'b1;
        end
      end
    end
  end

  // State registers and the result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      brightness    <= BRIGHT_RESET;
      slot_counter  <= '0;
      current_digit <= '0;
      segment_latch <= '0;
      grid_latch    <= '0;
      out_valid     <= 1'b0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
        digit_store[i] <= (i < CONV_DIGITS) ? DIGIT_W'(i + 1) : '0;
      end
    end else begin
      if (cfg_wr_en) begin
        brightness <= cfg_wr_data;
      end
      slot_counter  <= slot_counter_next;
      current_digit <= current_digit_next;
      segment_latch <= segment_latch_next;
      grid_latch    <= grid_latch_next;
      digit_store   <= digit_store_next;
      if (advance) begin
        out_valid <= item.valid;
      end
    end
  end

  // The latches hold still while a result waits, so they are the result.
  assign out_data.segments     = segment_latch;
  assign out_data.grid_enable  = grid_latch;
  assign out_data.active_digit = ACTIVE_W'(current_digit);

endmodule

// File: rtl/core/four_digit_display_multiplexer.sv
// ----------------------------------------------------------------------------
// four_digit_display_multiplexer
// Multiplexed seven-segment display scanner with decimal load and brightness.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while no result waits at the output
// and returns one result per item: the input register and two more register
// stages saturate the loaded value and split it by a hundred, and the commit
// step finishes the decimal split, updates the scan state and registers the
// result. A tick item advances the 126-count digit slot; a load item stores
// new digits and returns the unchanged latches. All stages move together, so a
// result left waiting at the output holds the whole pipeline and input ready
// drops until that result is taken. Brightness is written at any enabled clock
// edge and should change only while no item is in flight.
module four_digit_display_multiplexer
  import fddm_pkg::*;
#(
  parameter int unsigned NUM_DIGITS = 4
)
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_item_t            in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output out_item_t           out_data,
  input  logic                cfg_wr_en,
  input  logic [BRIGHT_W-1:0] cfg_wr_data
);

  logic        advance;
  split_item_t item;

  // The pipeline moves whenever the result register is empty or being taken.
  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  fddm_digit_split u_split (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .in_valid (in_valid),
    .in_data  (in_data),
    .item     (item)
  );

  fddm_scan #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .item        (item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_valid   (out_valid),
    .out_data    (out_data)
  );

endmodule

// File: rtl/core/fddm_checker.sv
// ----------------------------------------------------------------------------
// fddm_checker
// Port-level checks for the display multiplexer, bound to the top level.
// ----------------------------------------------------------------------------
module fddm_checker
  import fddm_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // A result that is not taken stays as it was.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // At most one grid is driven at any time.
  assert property (@(posedge clk) disable iff (rst)
    $countones(out_data.grid_enable) <= 1)
    else $error("more than one grid driven");

  // A lit grid always belongs to the digit being scanned.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.grid_enable != '0) |->
      out_data.grid_enable == (GRID_W'(1) << out_data.active_digit))
    else $error("grid does not match active digit");

  // Reset leaves no result pending and all drives dark.
  assert property (@(posedge clk)
    rst |=> !out_valid && (out_data.grid_enable == '0) && (out_data.segments == '0))
    else $error("drives not dark after reset");

endmodule

bind four_digit_display_multiplexer fddm_checker u_checker (.*);
